// ----- rtl/lcdtx_pkg.sv -----
// shared types, constants and the init nibble table for the lcd text writer
// no dependencies; the core, front, queue and back end refer to it by scoped names
package lcdtx_pkg;

	localparam int LINE_WIDTH = 16;
	localparam int MAX_CHARS  = 32;
	localparam int ROW_COUNT  = 2;

	localparam int ROW_W   = $clog2(ROW_COUNT + 1);
	localparam int COL_W   = $clog2(LINE_WIDTH + 1);
	localparam int TAKEN_W = $clog2(MAX_CHARS + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int NIB_IDX_W = 4;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// nibble positions of the fixed sequence (init, and start is its tail)
	localparam logic [NIB_IDX_W-1:0] INIT_FIRST  = 4'd0;
	localparam logic [NIB_IDX_W-1:0] START_FIRST = 4'd10;
	localparam logic [NIB_IDX_W-1:0] SEQ_LAST    = 4'd13;

	// nibble positions of a text job: character, then cursor address
	localparam logic [NIB_IDX_W-1:0] TXT_CHAR_HI   = 4'd0;
	localparam logic [NIB_IDX_W-1:0] TXT_CHAR_LO   = 4'd1;
	localparam logic [NIB_IDX_W-1:0] TXT_CURSOR_HI = 4'd2;
	localparam logic [NIB_IDX_W-1:0] TXT_CURSOR_LO = 4'd3;

	localparam logic [7:0] BACKLIGHT_RESET = 8'd8;
	localparam logic [7:0] ENABLE_RESET    = 8'd4;
	localparam logic [7:0] SELECT_RESET    = 8'd1;
	localparam logic [6:0] LINE_BASE_RESET = 7'd64;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_START = 2'd1,
		CMD_CHAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_BACKLIGHT = 2'd0,
		REG_ENABLE    = 2'd1,
		REG_SELECT    = 2'd2,
		REG_LINE_BASE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] backlight_mask;
		logic [7:0] enable_mask;
		logic [7:0] select_mask;
		logic [6:0] second_line_base;
	} cfg_t;

	// one unit of work for the back end: a run of nibbles, two bytes each
	typedef struct packed {
		logic                 is_text;
		logic [7:0]           data;
		logic [NIB_IDX_W-1:0] first;
		logic [NIB_IDX_W-1:0] stop;
	} job_t;

	// 0x30 x3, 0x20 (upper nibbles), 0x28, 0x0c, 0x06, 0x01, 0x80
	function automatic logic [3:0] seq_nibble(input logic [NIB_IDX_W-1:0] idx);
		logic [3:0] nib;
		case (idx)
			4'd0:    nib = 4'h3;
			4'd1:    nib = 4'h3;
			4'd2:    nib = 4'h3;
			4'd3:    nib = 4'h2;
			4'd4:    nib = 4'h2;
			4'd5:    nib = 4'h8;
			4'd6:    nib = 4'h0;
			4'd7:    nib = 4'hC;
			4'd8:    nib = 4'h0;
			4'd9:    nib = 4'h6;
			4'd10:   nib = 4'h0;
			4'd11:   nib = 4'h1;
			4'd12:   nib = 4'h8;
			4'd13:   nib = 4'h0;
			default: nib = 4'h0;
		endcase
		return nib;
	endfunction

endpackage

// ----- rtl/lcdtx_in_if.sv -----
// input channel of the lcd text writer: command, character, message end
// uses no package
interface lcdtx_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] char_code;
	logic       message_end;

	modport source(output valid, output cmd, output char_code, output message_end,
		input ready);
	modport sink(input valid, input cmd, input char_code, input message_end,
		output ready);
endinterface

// ----- rtl/lcdtx_out_if.sv -----
// output channel of the lcd text writer: one expander byte per beat
// uses no package
interface lcdtx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic       last;

	modport source(output valid, output bus_byte, output last, input ready);
	modport sink(input valid, input bus_byte, input last, output ready);
endinterface

// ----- rtl/char_lcd_text_to_expander_bytes_core.sv -----
// Text writer for a two-line HD44780 character display behind an I2C port
// expander in 4-bit mode. Each command (init, start message, character) turns
// into nibbles, each nibble into two expander bytes (enable high, then low),
// delivered one byte per clock while the output side takes them: a plain
// character gives 4 bytes, a character that wraps onto the second row 8, a
// newline 4 (none on the last row), start 8 and init 28. The byte emitter sets
// the rate; the front end takes a new command every cycle while the two-entry
// job queue has room.
// depends on lcdtx_pkg, lcdtx_in_if, lcdtx_out_if, lcdtx_front, lcdtx_queue, lcdtx_back
module char_lcd_text_to_expander_bytes_core (
	input  logic       clk,
	input  logic       arst_n,
	lcdtx_in_if.sink   in_ch,
	lcdtx_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_data
);

	lcdtx_pkg::cfg_t cfg_q;
	lcdtx_pkg::job_t wr_job, rd_job;
	logic            push, room, avail, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.backlight_mask   <= lcdtx_pkg::BACKLIGHT_RESET;
			cfg_q.enable_mask      <= lcdtx_pkg::ENABLE_RESET;
			cfg_q.select_mask      <= lcdtx_pkg::SELECT_RESET;
			cfg_q.second_line_base <= lcdtx_pkg::LINE_BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				lcdtx_pkg::REG_BACKLIGHT: cfg_q.backlight_mask   <= cfg_data;
				lcdtx_pkg::REG_ENABLE:    cfg_q.enable_mask      <= cfg_data;
				lcdtx_pkg::REG_SELECT:    cfg_q.select_mask      <= cfg_data;
				lcdtx_pkg::REG_LINE_BASE: cfg_q.second_line_base <= cfg_data[6:0];
				default:                  cfg_q                  <= cfg_q;
			endcase
		end
	end

	lcdtx_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.room   (room),
		.push   (push),
		.job    (wr_job)
	);

	lcdtx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.room   (room),
		.avail  (avail),
		.pop    (pop),
		.rd_job (rd_job)
	);

	lcdtx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.avail  (avail),
		.rd_job (rd_job),
		.pop    (pop),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("job issued into a full queue");

	a_job_order: assert property (@(posedge clk) disable iff (!arst_n)
		avail |-> rd_job.first <= rd_job.stop)
		else $error("queued job has an empty nibble run");

	a_init_issues: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.cmd == lcdtx_pkg::CMD_INIT) |-> push)
		else $error("init command produced no job");
`endif

endmodule

// ----- rtl/lcdtx_front.sv -----
// front end: accepts commands, tracks cursor and message state, issues jobs
// depends on lcdtx_pkg and lcdtx_in_if
module lcdtx_front (
	input  logic               clk,
	input  logic               arst_n,
	lcdtx_in_if.sink           in_ch,
	input  logic               room,
	output logic               push,
	output lcdtx_pkg::job_t    job
);

	logic [lcdtx_pkg::ROW_W-1:0]   row_q, row_d, row_inc;
	logic [lcdtx_pkg::COL_W-1:0]   col_q, col_d, col_inc;
	logic [lcdtx_pkg::TAKEN_W-1:0] taken_q, taken_d;
	logic                          open_q, open_d;
	logic                          emit;
	logic                          accept;

	assign in_ch.ready = room;
	assign accept      = in_ch.valid && room;
	assign push        = accept && emit;
	assign row_inc     = row_q + 1'b1;
	assign col_inc     = col_q + 1'b1;

	always_comb begin
		row_d       = row_q;
		col_d       = col_q;
		taken_d     = taken_q;
		open_d      = open_q;
		emit        = 1'b0;
		job.is_text = 1'b0;
		job.data    = in_ch.char_code;
		job.first   = lcdtx_pkg::INIT_FIRST;
		job.stop    = lcdtx_pkg::SEQ_LAST;
		case (in_ch.cmd)
			lcdtx_pkg::CMD_INIT: begin
				emit    = 1'b1;
				row_d   = '0;
				col_d   = '0;
				taken_d = '0;
				open_d  = 1'b0;
			end
			lcdtx_pkg::CMD_START: begin
				emit      = 1'b1;
				job.first = lcdtx_pkg::START_FIRST;
				row_d     = '0;
				col_d     = '0;
				taken_d   = '0;
				open_d    = 1'b1;
			end
			lcdtx_pkg::CMD_CHAR: begin
				job.is_text = 1'b1;
				if (open_q && row_q < lcdtx_pkg::ROW_W'(lcdtx_pkg::ROW_COUNT)
						&& taken_q < lcdtx_pkg::TAKEN_W'(lcdtx_pkg::MAX_CHARS)) begin
					taken_d = taken_q + 1'b1;
					if (in_ch.char_code == lcdtx_pkg::NEWLINE_CODE) begin
						row_d     = row_inc;
						col_d     = '0;
						emit      = row_inc < lcdtx_pkg::ROW_W'(lcdtx_pkg::ROW_COUNT);
						job.first = lcdtx_pkg::TXT_CURSOR_HI;
						job.stop  = lcdtx_pkg::TXT_CURSOR_LO;
					end else begin
						emit      = 1'b1;
						job.first = lcdtx_pkg::TXT_CHAR_HI;
						job.stop  = lcdtx_pkg::TXT_CHAR_LO;
						col_d     = col_inc;
						if (col_inc >= lcdtx_pkg::COL_W'(lcdtx_pkg::LINE_WIDTH)) begin
							row_d = row_inc;
							col_d = '0;
							// line wrap also moves the display address when a further row follows
							if (row_inc < lcdtx_pkg::ROW_W'(lcdtx_pkg::ROW_COUNT)) begin
								job.stop = lcdtx_pkg::TXT_CURSOR_LO;
							end
						end
					end
				end
				if (in_ch.message_end) begin
					open_d = 1'b0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			taken_q <= '0;
			open_q  <= 1'b0;
		end else if (accept) begin
			row_q   <= row_d;
			col_q   <= col_d;
			taken_q <= taken_d;
			open_q  <= open_d;
		end
	end

endmodule

// ----- rtl/lcdtx_queue.sv -----
// short job queue between front and back end
// depends on lcdtx_pkg
module lcdtx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lcdtx_pkg::job_t wr_job,
	output logic            room,
	output logic            avail,
	input  logic            pop,
	output lcdtx_pkg::job_t rd_job
);

	lcdtx_pkg::job_t                  mem_q [lcdtx_pkg::QUEUE_DEPTH];
	logic [lcdtx_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [lcdtx_pkg::QCNT_W-1:0]     count_q;
	logic                             do_push, do_pop;

	assign room    = count_q != lcdtx_pkg::QCNT_W'(lcdtx_pkg::QUEUE_DEPTH);
	assign avail   = count_q != '0;
	assign do_push = push && room;
	assign do_pop  = pop && avail;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == lcdtx_pkg::QPTR_W'(lcdtx_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == lcdtx_pkg::QPTR_W'(lcdtx_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/lcdtx_back.sv -----
// back end: walks a job nibble by nibble and emits two expander bytes per nibble
// depends on lcdtx_pkg and lcdtx_out_if
module lcdtx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lcdtx_pkg::cfg_t cfg,
	input  logic            avail,
	input  lcdtx_pkg::job_t rd_job,
	output logic            pop,
	lcdtx_out_if.source     out_ch
);

	lcdtx_pkg::job_t                 job_q;
	logic                            busy_q;
	logic [lcdtx_pkg::NIB_IDX_W-1:0] idx_q;
	logic                            phase_q;
	logic                            valid_q;
	logic [7:0]                      byte_q;
	logic                            last_q;
	logic                            advance, final_beat;
	logic [3:0]                      nib;
	logic [7:0]                      sel, next_byte;

	assign advance    = busy_q && (!valid_q || out_ch.ready);
	assign final_beat = phase_q && idx_q == job_q.stop;
	assign pop        = avail && (!busy_q || (advance && final_beat));

	always_comb begin
		if (job_q.is_text) begin
			case (idx_q)
				lcdtx_pkg::TXT_CHAR_HI:   nib = job_q.data[7:4];
				lcdtx_pkg::TXT_CHAR_LO:   nib = job_q.data[3:0];
				lcdtx_pkg::TXT_CURSOR_HI: nib = {1'b1, cfg.second_line_base[6:4]};
				lcdtx_pkg::TXT_CURSOR_LO: nib = cfg.second_line_base[3:0];
				default:                  nib = 4'h0;
			endcase
		end else begin
			nib = lcdtx_pkg::seq_nibble(idx_q);
		end
		sel = (job_q.is_text && idx_q <= lcdtx_pkg::TXT_CHAR_LO) ? cfg.select_mask : 8'h00;
		// enable is high on the first byte of each pair
		next_byte = {nib, 4'h0} | sel | cfg.backlight_mask
			| (phase_q ? 8'h00 : cfg.enable_mask);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= next_byte;
			last_q <= final_beat;
		end
		if (pop) begin
			job_q <= rd_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			phase_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				phase_q <= !phase_q;
				if (phase_q) begin
					idx_q <= idx_q + 1'b1;
				end
				if (final_beat) begin
					busy_q <= 1'b0;
				end
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				busy_q  <= 1'b1;
				idx_q   <= rd_job.first;
				phase_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid    = valid_q;
	assign out_ch.bus_byte = byte_q;
	assign out_ch.last     = last_q;

endmodule
